// File: rtl/bdd_pkg.sv
`default_nettype none

package bdd_pkg;

    // Storage geometry.
    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OFF_W   = PTR_W + 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // Fixed field widths of the transaction payloads.
    localparam int CMD_W       = 3;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value_in;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0]     value_out;
        logic [STATUS_W-1:0]    status;
        logic [COUNT_OUT_W-1:0] count;
    } out_item_t;

    // One access to the entry memory.
    typedef struct packed {
        logic              we;
        logic [PTR_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [PTR_W-1:0]  raddr;
    } mem_req_t;

    // Physical address of the entry at a logical offset from the front.
    function automatic logic [PTR_W-1:0] wrap_addr(input logic [PTR_W-1:0] base,
                                                   input logic [OFF_W-1:0] off);
        logic [OFF_W-1:0] sum;
        sum = OFF_W'(base) + off;
        if (sum >= OFF_W'(DEPTH)) begin
            sum = sum - OFF_W'(DEPTH);
        end
        return PTR_W'(sum);
    endfunction

endpackage

`default_nettype wire

// File: rtl/bounded_deque_with_delete_top.sv
`default_nettype none

// Bounded double-ended queue with delete by value. The block holds up to
// bdd_pkg::DEPTH words as a ring in a single-port-read, single-port-write
// memory with a front pointer and a count, and works on one transaction at
// a time. Push commands, full pushes, empty pops, deletes on an empty
// store and unused codes go from acceptance straight to the result state;
// a pop first waits in S_POP_WAIT for the registered read data of the
// memory. A delete reads one entry per cycle from the front until it
// finds a match at position k (or reaches the end), then moves each later
// entry one place forward at one entry per cycle. A new transaction is
// taken while the previous result still waits in the output register.
module bounded_deque_with_delete_top (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire bdd_pkg::in_item_t   s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output bdd_pkg::out_item_t       m_data
);

    bdd_pkg::mem_req_t          mem_req;
    logic [bdd_pkg::DATA_W-1:0] mem_rdata;

    bdd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    bdd_ram u_ram (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// File: rtl/bdd_ram.sv
`default_nettype none

// Entry store: one write port and one read port, read data registered.
module bdd_ram (
    input  wire logic                        aclk,
    input  wire bdd_pkg::mem_req_t           req,
    output logic [bdd_pkg::DATA_W-1:0]       rdata
);

    logic [bdd_pkg::DATA_W-1:0] mem [bdd_pkg::DEPTH];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.re) begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/bdd_ctrl.sv
`default_nettype none

// Command sequencer: keeps the front pointer and the count, drives the
// entry memory and holds the result register.
module bdd_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire bdd_pkg::in_item_t           s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output bdd_pkg::out_item_t               m_data,
    output bdd_pkg::mem_req_t                mem_req,
    input  wire logic [bdd_pkg::DATA_W-1:0]  mem_rdata
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_POP_WAIT = 6'b000010,
        S_SRCH_RD  = 6'b000100,
        S_SRCH_CMP = 6'b001000,
        S_SHIFT    = 6'b010000,
        S_RESULT   = 6'b100000
    } state_t;

    state_t                            state_reg, state_next;
    logic [bdd_pkg::PTR_W-1:0]         head_reg, head_next;
    logic [bdd_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [bdd_pkg::PTR_W-1:0]         idx_reg, idx_next;
    logic [bdd_pkg::DATA_W-1:0]        key_reg, key_next;
    logic [bdd_pkg::VALUE_W-1:0]       res_value_reg, res_value_next;
    logic [bdd_pkg::STATUS_W-1:0]      res_status_reg, res_status_next;
    logic                              m_valid_reg, m_valid_next;
    bdd_pkg::out_item_t                m_data_reg, m_data_next;

    logic [bdd_pkg::OFF_W-1:0]         cnt_off;
    logic [bdd_pkg::OFF_W-1:0]         idx_p1;
    logic [bdd_pkg::OFF_W-1:0]         idx_p2;
    logic                              is_full;
    logic                              is_empty;
    logic                              out_free;
    logic [bdd_pkg::DATA_W-1:0]        in_word;

    function automatic logic [bdd_pkg::PTR_W-1:0] PTR_W_INC(
        input logic [bdd_pkg::PTR_W-1:0] v);
        return v + bdd_pkg::PTR_W'(1);
    endfunction

    assign cnt_off  = bdd_pkg::OFF_W'(cnt_reg);
    assign idx_p1   = bdd_pkg::OFF_W'(idx_reg) + bdd_pkg::OFF_W'(1);
    assign idx_p2   = bdd_pkg::OFF_W'(idx_reg) + bdd_pkg::OFF_W'(2);
    assign is_full  = (cnt_reg == bdd_pkg::CNT_W'(bdd_pkg::DEPTH));
    assign is_empty = (cnt_reg == '0);
    assign out_free = !m_valid_reg || m_ready;
    assign in_word  = bdd_pkg::DATA_W'(s_data.value_in);

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Next-state and memory access logic.
    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        key_next        = key_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        mem_req         = '0;

        // A taken result frees the output register.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    res_value_next  = '0;
                    res_status_next = bdd_pkg::ST_OK;
                    key_next        = in_word;
                    idx_next        = '0;
                    state_next      = S_RESULT;
                    case (s_data.cmd)
                        bdd_pkg::CMD_PUSH_BACK: begin
                            if (is_full) begin
                                res_status_next = bdd_pkg::ST_FULL;
                            end else begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = bdd_pkg::wrap_addr(head_reg, cnt_off);
                                mem_req.wdata = in_word;
                                cnt_next      = cnt_reg + bdd_pkg::CNT_W'(1);
                            end
                        end
                        bdd_pkg::CMD_POP_BACK: begin
                            if (is_empty) begin
                                res_status_next = bdd_pkg::ST_EMPTY;
                            end else begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = bdd_pkg::wrap_addr(head_reg,
                                                    cnt_off - bdd_pkg::OFF_W'(1));
                                cnt_next      = cnt_reg - bdd_pkg::CNT_W'(1);
                                state_next    = S_POP_WAIT;
                            end
                        end
                        bdd_pkg::CMD_PUSH_FRONT: begin
                            if (is_full) begin
                                res_status_next = bdd_pkg::ST_FULL;
                            end else begin
                                head_next = (head_reg == '0) ?
                                    bdd_pkg::PTR_W'(bdd_pkg::DEPTH - 1) :
                                    head_reg - bdd_pkg::PTR_W'(1);
                                mem_req.we    = 1'b1;
                                mem_req.waddr = head_next;
                                mem_req.wdata = in_word;
                                cnt_next      = cnt_reg + bdd_pkg::CNT_W'(1);
                            end
                        end
                        bdd_pkg::CMD_POP_FRONT: begin
                            if (is_empty) begin
                                res_status_next = bdd_pkg::ST_EMPTY;
                            end else begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = head_reg;
                                head_next     = bdd_pkg::wrap_addr(head_reg,
                                                    bdd_pkg::OFF_W'(1));
                                cnt_next      = cnt_reg - bdd_pkg::CNT_W'(1);
                                state_next    = S_POP_WAIT;
                            end
                        end
                        bdd_pkg::CMD_DELETE: begin
                            if (is_empty) begin
                                res_status_next = bdd_pkg::ST_NOMATCH;
                            end else begin
                                state_next = S_SRCH_RD;
                            end
                        end
                        default: begin
                            // Unused codes leave the store alone.
                        end
                    endcase
                end
            end

            S_POP_WAIT: begin
                res_value_next = bdd_pkg::VALUE_W'(mem_rdata);
                state_next     = S_RESULT;
            end

            // Fetch the entry at the search index.
            S_SRCH_RD: begin
                mem_req.re    = 1'b1;
                mem_req.raddr = bdd_pkg::wrap_addr(head_reg, bdd_pkg::OFF_W'(idx_reg));
                state_next    = S_SRCH_CMP;
            end

            // Compare one entry per cycle while the next one is fetched.
            S_SRCH_CMP: begin
                mem_req.re    = 1'b1;
                mem_req.raddr = bdd_pkg::wrap_addr(head_reg, idx_p1);
                if (mem_rdata == key_reg) begin
                    if (idx_p1 == cnt_off) begin
                        cnt_next   = cnt_reg - bdd_pkg::CNT_W'(1);
                        state_next = S_RESULT;
                    end else begin
                        state_next = S_SHIFT;
                    end
                end else if (idx_p1 == cnt_off) begin
                    res_status_next = bdd_pkg::ST_NOMATCH;
                    state_next      = S_RESULT;
                end else begin
                    idx_next = PTR_W_INC(idx_reg);
                end
            end

            // Move the entry behind the index one place toward the front.
            S_SHIFT: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = bdd_pkg::wrap_addr(head_reg, bdd_pkg::OFF_W'(idx_reg));
                mem_req.wdata = mem_rdata;
                if (idx_p2 == cnt_off) begin
                    cnt_next   = cnt_reg - bdd_pkg::CNT_W'(1);
                    state_next = S_RESULT;
                end else begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = bdd_pkg::wrap_addr(head_reg, idx_p2);
                    idx_next      = PTR_W_INC(idx_reg);
                end
            end

            // Hand the result to the output register once it is free.
            S_RESULT: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_data_next.value_out = res_value_reg;
                    m_data_next.status    = res_status_reg;
                    m_data_next.count     = bdd_pkg::COUNT_OUT_W'(cnt_reg);
                    state_next            = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        key_reg        <= key_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
    end

endmodule

`default_nettype wire

// File: rtl/bdd_checker.sv
`default_nettype none

// Port-level checks on the result channel.
module bdd_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire bdd_pkg::out_item_t m_data
);

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // The count never exceeds the capacity.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.count <= bdd_pkg::COUNT_OUT_W'(bdd_pkg::DEPTH))
        else $error("count above capacity");

    // A rejected push is only reported on a full store.
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == bdd_pkg::ST_FULL
            |-> m_data.count == bdd_pkg::COUNT_OUT_W'(bdd_pkg::DEPTH)
                && m_data.value_out == '0)
        else $error("full status with room left");

    // An empty pop reports an empty store and a zero word.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == bdd_pkg::ST_EMPTY
            |-> m_data.count == '0 && m_data.value_out == '0)
        else $error("empty status on a nonempty store");

    // A failed delete returns no word.
    a_nomatch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == bdd_pkg::ST_NOMATCH |-> m_data.value_out == '0)
        else $error("failed delete returned a word");

endmodule

bind bounded_deque_with_delete_top bdd_checker u_bdd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
